// File: src/aes_block_encrypt_defines.svh
// Assertion macros shared by the block's RTL.
`ifndef AES_BLOCK_ENCRYPT_DEFINES_SVH
`define AES_BLOCK_ENCRYPT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AES_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AES_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/aes_pkg.sv
package aes_pkg;

  // Pipeline and key schedule dimensions.
  localparam int unsigned NumStages = 15;
  localparam int unsigned NumKeyWords = 60;
  localparam int unsigned MaxRounds = 14;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegKeyLen = 3'd0;
  localparam logic [2:0] RegKey0 = 3'd1;
  localparam logic [2:0] RegKey1 = 3'd2;
  localparam logic [2:0] RegKey2 = 3'd3;
  localparam logic [2:0] RegKey3 = 3'd4;

  // Key length codes.
  localparam logic [1:0] KeyLen128 = 2'd0;
  localparam logic [1:0] KeyLen192 = 2'd1;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } aes_out_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] aes_sbox(input logic [7:0] b);
    return Sbox[b];
  endfunction

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] aes_xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] aes_sub_word(input logic [31:0] w);
    return {aes_sbox(w[31:24]), aes_sbox(w[23:16]), aes_sbox(w[15:8]), aes_sbox(w[7:0])};
  endfunction

  // SubBytes and ShiftRows; byte 4*column+row, row r rotates left by r columns.
  function automatic logic [127:0] aes_sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(4*c+r) +: 8] = aes_sbox(s[8*(4*((c+r)&3)+r) +: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] aes_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a, b, x, d;
    for (int c = 0; c < 4; c++) begin
      a = s[32*c +: 8];
      b = s[32*c+8 +: 8];
      x = s[32*c+16 +: 8];
      d = s[32*c+24 +: 8];
      t[32*c +: 8] = aes_xtime(a ^ b) ^ b ^ x ^ d;
      t[32*c+8 +: 8] = aes_xtime(b ^ x) ^ x ^ d ^ a;
      t[32*c+16 +: 8] = aes_xtime(x ^ d) ^ d ^ a ^ b;
      t[32*c+24 +: 8] = aes_xtime(d ^ a) ^ a ^ b ^ x;
    end
    return t;
  endfunction

endpackage

// File: src/aes_block_encrypt.sv
// Channel   Handshake                      Payload
// input     start / busy                   plain_i  (plain_low, plain_high)
// result    done_o strobe, one cycle       cipher_o (cipher_low, cipher_high)
// config    APB psel/penable/pwrite        paddr, pwdata, prdata; pready tied high
//
// One item can enter every cycle while busy is low; each goes through the pipeline to done_o,
// one AES round per pipeline register (key add, then 14 round stages; stages past
// the selected round count pass the block through).
// After reset and after every key or key length write, the key schedule unit
// produces one 32-bit word per cycle until all 60 words are made; busy stays high meanwhile.
// Results cannot be stalled; the pipeline never holds.
`include "aes_block_encrypt_defines.svh"

module aes_block_encrypt import aes_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  aes_in_t     plain_i,
  output logic        done_o,
  output aes_out_t    cipher_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [1:0]   key_len_q;
  logic [255:0] key_q;
  logic         cfg_wr;
  logic [2:0]   cfg_idx;

  logic         kx_busy_q;
  logic [5:0]   kx_cnt_q;
  logic [2:0]   kx_mod_q;
  logic [7:0]   rcon_q;
  logic [31:0]  kw_q [NumKeyWords];
  logic [31:0]  kw_new, kw_prev, kw_back;
  logic [2:0]   nk_m1;
  logic [3:0]   nr;

  logic [127:0] st_q [NumStages];
  logic [127:0] st_d [NumStages];
  logic [NumStages-1:0] vld_q;
  logic         accept;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[5:3];
  assign accept  = start && !busy;
  assign busy    = kx_busy_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= '0;
      key_q     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegKeyLen: key_len_q <= pwdata[1:0];
        RegKey0:   key_q[63:0] <= pwdata;
        RegKey1:   key_q[127:64] <= pwdata;
        RegKey2:   key_q[191:128] <= pwdata;
        RegKey3:   key_q[255:192] <= pwdata;
        default:   ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      RegKeyLen: prdata = {62'd0, key_len_q};
      RegKey0:   prdata = key_q[63:0];
      RegKey1:   prdata = key_q[127:64];
      RegKey2:   prdata = key_q[191:128];
      RegKey3:   prdata = key_q[255:192];
      default:   prdata = '0;
    endcase
  end

  // Key length decode; the unused code behaves as a 256-bit key.
  always_comb begin
    case (key_len_q)
      KeyLen128: begin
        nk_m1 = 3'd3;
        nr    = 4'd10;
      end
      KeyLen192: begin
        nk_m1 = 3'd5;
        nr    = 4'd12;
      end
      default: begin
        nk_m1 = 3'd7;
        nr    = 4'd14;
      end
    endcase
  end

  // Next schedule word: key words first, then the expansion recurrence.
  assign kw_prev = kw_q[0];
  assign kw_back = kw_q[{3'd0, nk_m1}];
  always_comb begin
    if (kx_cnt_q <= {3'd0, nk_m1}) begin
      kw_new = key_q[32*kx_cnt_q[2:0] +: 32];
    end else if (kx_mod_q == 3'd0) begin
      kw_new = kw_back ^ {aes_sbox(kw_prev[7:0]), aes_sbox(kw_prev[31:24]),
                          aes_sbox(kw_prev[23:16]), aes_sbox(kw_prev[15:8]) ^ rcon_q};
    end else if (nk_m1 == 3'd7 && kx_mod_q == 3'd4) begin
      kw_new = kw_back ^ aes_sub_word(kw_prev);
    end else begin
      kw_new = kw_back ^ kw_prev;
    end
  end

  // Schedule control: one word per cycle, restarted by any key or key length register write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kx_busy_q <= 1'b1;
      kx_cnt_q  <= '0;
      kx_mod_q  <= '0;
      rcon_q    <= 8'h01;
    end else if (cfg_wr && cfg_idx <= RegKey3) begin
      kx_busy_q <= 1'b1;
      kx_cnt_q  <= '0;
      kx_mod_q  <= '0;
      rcon_q    <= 8'h01;
    end else if (kx_busy_q) begin
      kx_cnt_q  <= kx_cnt_q + 6'd1;
      kx_mod_q  <= (kx_mod_q == nk_m1) ? 3'd0 : kx_mod_q + 3'd1;
      if (kx_cnt_q > {3'd0, nk_m1} && kx_mod_q == 3'd0) begin
        rcon_q <= aes_xtime(rcon_q);
      end
      if (kx_cnt_q == 6'(NumKeyWords - 1)) begin
        kx_busy_q <= 1'b0;
      end
    end
  end

  // Schedule shift line; word i ends at tap NumKeyWords-1-i.
  always_ff @(posedge clk_i) begin
    if (kx_busy_q) begin
      kw_q[0] <= kw_new;
      for (int i = 1; i < NumKeyWords; i++) begin
        kw_q[i] <= kw_q[i-1];
      end
    end
  end

  // Round datapath: stage 0 adds the first key, stage r runs round r.
  always_comb begin
    logic [127:0] sub;
    logic [127:0] rk;
    st_d[0] = {plain_i.plain_high, plain_i.plain_low} ^
              {kw_q[NumKeyWords-4], kw_q[NumKeyWords-3],
               kw_q[NumKeyWords-2], kw_q[NumKeyWords-1]};
    for (int r = 1; r <= MaxRounds; r++) begin
      sub = aes_sub_shift(st_q[r-1]);
      rk  = {kw_q[NumKeyWords-4-4*r], kw_q[NumKeyWords-3-4*r],
             kw_q[NumKeyWords-2-4*r], kw_q[NumKeyWords-1-4*r]};
      if (4'(r) < nr) begin
        st_d[r] = aes_mix(sub) ^ rk;
      end else if (4'(r) == nr) begin
        st_d[r] = sub ^ rk;
      end else begin
        st_d[r] = st_q[r-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < NumStages; r++) begin
      st_q[r] <= st_d[r];
    end
  end

  // Valid bits travel with the blocks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NumStages-2:0], accept};
    end
  end

  assign done_o   = vld_q[NumStages-1];
  assign cipher_o = aes_out_t'(st_q[NumStages-1]);

  // Checks.
  `AES_ASSERT_NEXT(a_no_entry_in_sched, kx_busy_q, !vld_q[0], "item entered during key schedule")
  `AES_ASSERT_NOW(a_done_has_source, done_o, $past(accept, NumStages), "result without item")
  `AES_ASSERT_NEXT(a_key_write_busy, cfg_wr && cfg_idx <= RegKey3, busy, "key write kept ready")
  `AES_ASSERT_NEXT(a_sched_ends, kx_busy_q && kx_cnt_q == 6'(NumKeyWords - 1) && !cfg_wr,
                   !kx_busy_q, "key schedule overran")

endmodule

// File: tb/tb_aes_block_encrypt.sv
// Scoreboard: predicts the ciphertext of every accepted item and checks results in order.
class cipher_scoreboard;
  bit [1:0]  key_len;
  bit [63:0] key_q [4];
  aes_pkg::aes_out_t pending_cipher [$];
  int errors;

  function new();
    key_len = 2'd0;
    foreach (key_q[i]) key_q[i] = '0;
    errors = 0;
  endfunction

  // Mirror a register write; indexes past the last key register are ignored.
  function void set_reg(bit [2:0] idx, bit [63:0] v);
    if (idx == aes_pkg::RegKeyLen) begin
      key_len = v[1:0];
    end else if (idx <= aes_pkg::RegKey3) begin
      key_q[idx - 1] = v;
    end
  endfunction

  static function bit [7:0] gf_times2(bit [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function aes_pkg::aes_out_t encrypt(aes_pkg::aes_in_t p);
    bit [7:0] rk [240];
    bit [7:0] st [16];
    bit [7:0] tmp [16];
    bit [7:0] w [4];
    bit [7:0] f, rc, a, b, x, d;
    int nk, nr;
    aes_pkg::aes_out_t res;
    // Key lengths of 256 bits and the spare code both take eight key words.
    nk = (key_len == aes_pkg::KeyLen128) ? 4 : (key_len == aes_pkg::KeyLen192) ? 6 : 8;
    nr = nk + 6;
    for (int i = 0; i < 32; i++) rk[i] = key_q[i / 8][8 * (i % 8) +: 8];
    // Key schedule, one 32-bit word at a time.
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[4 * (i - 1) + j];
      if (i % nk == 0) begin
        rc = 8'h01;
        for (int k = 1; k < i / nk; k++) rc = gf_times2(rc);
        f = w[0];
        w[0] = aes_pkg::Sbox[w[1]] ^ rc;
        w[1] = aes_pkg::Sbox[w[2]];
        w[2] = aes_pkg::Sbox[w[3]];
        w[3] = aes_pkg::Sbox[f];
      end else if (nk > 6 && i % nk == 4) begin
        for (int j = 0; j < 4; j++) w[j] = aes_pkg::Sbox[w[j]];
      end
      for (int j = 0; j < 4; j++) rk[4 * i + j] = rk[4 * (i - nk) + j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) begin
      st[i] = ((i < 8) ? p.plain_low[8 * i +: 8] : p.plain_high[8 * (i - 8) +: 8]) ^ rk[i];
    end
    // Rounds; the last one skips the column mix.
    for (int r = 1; r <= nr; r++) begin
      for (int c = 0; c < 4; c++) begin
        for (int q = 0; q < 4; q++) tmp[4 * c + q] = aes_pkg::Sbox[st[4 * ((c + q) % 4) + q]];
      end
      if (r < nr) begin
        for (int c = 0; c < 4; c++) begin
          a = tmp[4 * c]; b = tmp[4 * c + 1]; x = tmp[4 * c + 2]; d = tmp[4 * c + 3];
          tmp[4 * c]     = gf_times2(a ^ b) ^ b ^ x ^ d;
          tmp[4 * c + 1] = gf_times2(b ^ x) ^ x ^ d ^ a;
          tmp[4 * c + 2] = gf_times2(x ^ d) ^ d ^ a ^ b;
          tmp[4 * c + 3] = gf_times2(d ^ a) ^ a ^ b ^ x;
        end
      end
      for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[16 * r + i];
    end
    for (int i = 0; i < 8; i++) begin
      res.cipher_low[8 * i +: 8]  = st[i];
      res.cipher_high[8 * i +: 8] = st[i + 8];
    end
    return res;
  endfunction

  function void note_plain(aes_pkg::aes_in_t p);
    pending_cipher.push_back(encrypt(p));
  endfunction

  function void check_cipher(aes_pkg::aes_out_t got);
    aes_pkg::aes_out_t exp_c;
    if (pending_cipher.size() == 0) begin
      $error("Result with no item outstanding: %h", got);
      errors++;
      return;
    end
    exp_c = pending_cipher.pop_front();
    if (got.cipher_low !== exp_c.cipher_low) begin
      $error("cipher_low: expected %h, actual %h", exp_c.cipher_low, got.cipher_low);
      errors++;
    end
    if (got.cipher_high !== exp_c.cipher_high) begin
      $error("cipher_high: expected %h, actual %h", exp_c.cipher_high, got.cipher_high);
      errors++;
    end
  endfunction
endclass

module tb_aes_block_encrypt;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KeyLen256 = 2'd2;
  localparam logic [1:0] KeyLenSpare = 2'd3;
  localparam logic [2:0] RegFirstUnused = 3'd5;
  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  aes_in_t     plain_i = '0;
  logic        done_o;
  aes_out_t    cipher_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  cipher_scoreboard sb = new();
  int sent_cnt = 0;
  int cycle_cnt = 0;

  aes_block_encrypt DUT (
    .clk_i, .rst_ni, .start, .busy, .plain_i, .done_o, .cipher_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watch both channels at each edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_plain(plain_i);
      if (done_o) sb.check_cipher(cipher_o);
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(idx, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold off until every expected ciphertext has come and the pipeline is empty.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_cipher.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_key(input logic [1:0] len, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    wait_drained();
    reg_write(RegKeyLen, {62'd0, len});
    reg_write(RegKey0, k0);
    reg_write(RegKey1, k1);
    reg_write(RegKey2, k2);
    reg_write(RegKey3, k3);
    // Writes past the last register must leave the key alone.
    for (int i = RegFirstUnused; i <= 7; i++) reg_write(3'(i), {$urandom, $urandom});
  endtask

  // Present one block and hold it until accepted; idles first at the phase's rate.
  task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
    int idle_pct;
    idle_pct = (sent_cnt < 280) ? 19 : (sent_cnt < 560) ? 65 : 0;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start   <= 1'b1;
    plain_i <= '{plain_high: hi, plain_low: lo};
    do @(posedge clk_i); while (busy);
    sent_cnt++;
  endtask

  function automatic logic [63:0] rand_half(input int kind);
    case (kind)
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_blocks(input int n);
    for (int i = 0; i < n; i++) begin
      send_block(rand_half(($urandom_range(9) < 8) ? 3 : $urandom_range(2)),
                 rand_half(($urandom_range(9) < 8) ? 3 : $urandom_range(2)));
      // One hold-off in the middle of the run until everything has come back.
      if (sent_cnt == 420) wait_drained();
    end
  endtask

  localparam logic [63:0] FipsK0 = 64'h0706050403020100;
  localparam logic [63:0] FipsK1 = 64'h0f0e0d0c0b0a0908;
  localparam logic [63:0] FipsK2 = 64'h1716151413121110;
  localparam logic [63:0] FipsK3 = 64'h1f1e1d1c1b1a1918;
  localparam logic [63:0] FipsPl = 64'h7766554433221100;
  localparam logic [63:0] FipsPh = 64'hffeeddccbbaa9988;

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset key, then each key length on the standard vectors and extremes.
    send_block('0, '0);
    send_block('1, '1);
    load_key(KeyLen128, FipsK0, FipsK1, FipsK2, FipsK3);
    send_block(FipsPl, FipsPh);
    send_block('0, '1);
    send_block(64'h1, 64'h8000000000000000);
    load_key(KeyLen192, FipsK0, FipsK1, FipsK2, FipsK3);
    send_block(FipsPl, FipsPh);
    send_block('1, '0);
    load_key(KeyLen256, FipsK0, FipsK1, FipsK2, FipsK3);
    send_block(FipsPl, FipsPh);
    send_block('0, '0);
    // The spare length code behaves as a 256-bit key.
    load_key(KeyLenSpare, FipsK0, FipsK1, FipsK2, FipsK3);
    send_block(FipsPl, FipsPh);
    send_block('1, '1);
    load_key(KeyLen256, '1, '1, '1, '1);
    send_block('0, '0);
    send_block('1, '1);
    load_key(KeyLen128, '1, '1, '0, '0);
    send_block(FipsPl, FipsPh);

    // Random blocks under a sequence of keys, extremes among them.
    load_key(KeyLen128, {$urandom, $urandom}, {$urandom, $urandom}, '1, '1);
    random_blocks(110);
    load_key(KeyLen192, {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom});
    random_blocks(110);
    load_key(KeyLen256, {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom});
    random_blocks(110);
    load_key(KeyLenSpare, {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom});
    random_blocks(100);
    load_key(KeyLen128, '0, '0, '0, '0);
    random_blocks(100);
    load_key(KeyLen256, '1, '1, '1, '1);
    random_blocks(100);
    load_key(KeyLen192, {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom});
    random_blocks(100);
    load_key(KeyLen128, {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom});
    random_blocks(100);

    wait_drained();
    if (sb.errors == 0 && sb.pending_cipher.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
